### rtl/csem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore
// Request and status codes, ring pointer helpers, and the command and
// status bundles that pass between the semaphore control and its wait queue.
// ----------------------------------------------------------------------------
package csem_pkg;

	// sizes
	localparam int QUEUE_LEN   = 16;
	localparam int PTR_W       = $clog2(QUEUE_LEN);
	localparam int THREAD_BITS = 16;
	localparam int FIELD_W     = 16;  // width of the thread and count ports
	localparam int CNT_W       = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [THREAD_BITS-1:0] tid_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// request codes
	typedef enum logic [2:0] {
		REQ_WAIT   = 3'd0,
		REQ_POST   = 3'd1,
		REQ_CANCEL = 3'd2,
		REQ_PROBE  = 3'd3,
		REQ_SET    = 3'd4
	} req_t;

	// status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_WOULD_BLK = 3'd2,
		ST_Q_FULL    = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_BAD_VALUE = 3'd5,
		ST_TIMED_OUT = 3'd6
	} status_t;

	// configuration register indexes
	typedef enum logic {
		CFG_BINARY    = 1'b0,
		CFG_RECURSIVE = 1'b1
	} cfg_idx_t;

	// control sequencer
	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_DECODE = 2'd1,
		FSM_QWAIT  = 2'd2
	} fsm_t;

	// wait queue operations
	typedef enum logic [2:0] {
		Q_NONE   = 3'd0,
		Q_PUSH   = 3'd1,
		Q_POP    = 3'd2,
		Q_PROBE  = 3'd3,
		Q_CANCEL = 3'd4
	} q_op_t;

	typedef struct packed {
		q_op_t op;
		tid_t  tid;
	} q_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic done;      // operation finished this cycle
		logic hit;       // scan found the thread
		tid_t head_tid;  // popped thread, valid with done of a pop
	} q_stat_t;

	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == PTR_W'(QUEUE_LEN - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ring_prev(input ptr_t p);
		ring_prev = (p == '0) ? PTR_W'(QUEUE_LEN - 1) : p - ptr_t'(1);
	endfunction

endpackage
`default_nettype wire

### rtl/csem_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_queue: FIFO ring of waiting thread ids
// Push, pop, and a one-entry-per-cycle scan through a single-port-read ring
// memory. The scan compares each entry against the thread id and, for a
// cancel, shifts every entry after the first match down by one slot.
// ----------------------------------------------------------------------------
module csem_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire csem_pkg::q_cmd_t cmd,
	output csem_pkg::q_stat_t     st
);
	import csem_pkg::*;

	tid_t  mem [QUEUE_LEN];
	ptr_t  head_q, tail_q;
	q_op_t mode_q;
	logic  issue_q;
	ptr_t  rd_ptr_q;
	logic  hit_q;
	tid_t  tid_q;
	logic  dv_s1;
	ptr_t  da_s1;
	tid_t  rdata_s1;

	logic  we;
	ptr_t  waddr, raddr;
	tid_t  wdata;
	logic  scan_start, pop_start, scanning, last;

	assign scan_start = (cmd.op == Q_PROBE) || (cmd.op == Q_CANCEL);
	assign pop_start  = (cmd.op == Q_POP);
	assign scanning   = (mode_q == Q_PROBE) || (mode_q == Q_CANCEL);
	assign last       = (da_s1 == tail_q);

	// memory port control: push write or compaction write, one read
	always_comb begin
		we    = 1'b0;
		waddr = tail_q;
		wdata = cmd.tid;
		raddr = (scan_start || pop_start) ? head_q : rd_ptr_q;
		if (cmd.op == Q_PUSH) begin
			we = 1'b1;
		end else if (dv_s1 && (mode_q == Q_CANCEL) && hit_q) begin
			we    = 1'b1;
			waddr = ring_prev(da_s1);
			wdata = rdata_s1;
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
		da_s1    <= raddr;
	end

	// status toward the control
	always_comb begin
		st.empty    = (head_q == tail_q);
		st.full     = (ring_next(tail_q) == head_q);
		st.done     = (cmd.op == Q_PUSH) ||
		              (dv_s1 && ((mode_q == Q_POP) || (scanning && last)));
		st.hit      = hit_q;
		st.head_tid = rdata_s1;
	end

	// pointers and scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			mode_q   <= Q_NONE;
			issue_q  <= 1'b0;
			rd_ptr_q <= '0;
			hit_q    <= 1'b0;
			tid_q    <= '0;
			dv_s1    <= 1'b0;
		end else begin
			if (cmd.op == Q_PUSH) begin
				tail_q <= ring_next(tail_q);
			end
			if (scan_start || pop_start) begin
				// first read goes to the head slot
				mode_q   <= cmd.op;
				tid_q    <= cmd.tid;
				hit_q    <= 1'b0;
				dv_s1    <= 1'b1;
				rd_ptr_q <= ring_next(head_q);
				issue_q  <= scan_start && (head_q != tail_q);
			end else begin
				dv_s1 <= issue_q;
				if (issue_q) begin
					rd_ptr_q <= ring_next(rd_ptr_q);
					issue_q  <= (rd_ptr_q != tail_q);
				end
				if (dv_s1 && (mode_q == Q_POP)) begin
					head_q <= ring_next(head_q);
					mode_q <= Q_NONE;
				end else if (dv_s1 && scanning) begin
					if (last) begin
						mode_q <= Q_NONE;
						if ((mode_q == Q_CANCEL) && hit_q) begin
							tail_q <= ring_prev(tail_q);
						end
					end else if (rdata_s1 == tid_q) begin
						hit_q <= 1'b1;
					end
				end
			end
		end
	end

	// checks
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == Q_PUSH) |-> (ring_next(tail_q) != head_q))
		else $error("push into a full ring");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == Q_POP) |-> (head_q != tail_q))
		else $error("pop from an empty ring");
	a_cmd_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != Q_NONE) |-> (mode_q == Q_NONE) && !dv_s1)
		else $error("queue command while an operation runs");

endmodule
`default_nettype wire

### rtl/counting_semaphore_with_wait_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_with_wait_queue: semaphore with FIFO wait queue
// Keeps the count and owner; wait, post, cancel, probe and set requests run
// one at a time through a small sequencer that drives the wait ring.
//
// Channel   Direction  Handshake             Payload
// request   in         start & !busy         req_type thread_id no_wait new_count
// result    out        done (one cycle)      status resume_valid resume_thread
//                                            in_queue count_value
// config    in         cfg_valid & cfg_ready cfg_index cfg_data
//
// Wait, set, post without waiters, overflow and bad requests: the result
// is decided in the decode state and registered into the strobe. Post with a
// waiter also waits for the ring read of the head. Cancel and probe scan the
// ring one entry a cycle up to the tail. busy is high from the accepting edge
// until the cycle of the strobe; a new request can be taken in the strobe
// cycle. The result is never held off. Reset clears count, owner, modes and
// ring pointers; ring contents are not cleared.
// ----------------------------------------------------------------------------
module counting_semaphore_with_wait_queue (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [2:0]                       req_type,
	input  wire  [csem_pkg::FIELD_W-1:0]     thread_id,
	input  wire                              no_wait,
	input  wire  [csem_pkg::FIELD_W-1:0]     new_count,
	output logic                             done,
	output logic [2:0]                       status,
	output logic                             resume_valid,
	output logic [csem_pkg::FIELD_W-1:0]     resume_thread,
	output logic                             in_queue,
	output logic [csem_pkg::FIELD_W-1:0]     count_value,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire                              cfg_index,
	input  wire                              cfg_data
);
	import csem_pkg::*;

	fsm_t    state_q, state_d;
	req_t    req_q;
	tid_t    tid_q;
	logic    nowait_q;
	cnt_t    nc_q;
	cnt_t    count_q, count_d;
	logic    owner_valid_q, owner_valid_d;
	tid_t    owner_q, owner_d;
	logic    binary_q, recursive_q;

	logic    done_q;
	status_t status_q, status_d;
	logic    rvalid_q, rvalid_d;
	tid_t    rthread_q, rthread_d;
	logic    inq_q, inq_d;
	logic    res_load;

	q_cmd_t  q_cmd;
	q_stat_t q_st;
	logic    need_ring;

	csem_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (q_cmd),
		.st     (q_st)
	);

	assign busy      = (state_q != FSM_IDLE);
	assign cfg_ready = 1'b1;

	// decode: requests that continue in the ring
	always_comb begin
		case (req_q)
			REQ_POST:   need_ring = (count_q < COUNT_MAX) && !q_st.empty;
			REQ_CANCEL: need_ring = 1'b1;
			REQ_PROBE:  need_ring = 1'b1;
			default:    need_ring = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:   if (start) state_d = FSM_DECODE;
			FSM_DECODE: state_d = need_ring ? FSM_QWAIT : FSM_IDLE;
			FSM_QWAIT:  if (q_st.done) state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// request execution and result
	always_comb begin
		count_d       = count_q;
		owner_valid_d = owner_valid_q;
		owner_d       = owner_q;
		status_d      = ST_OK;
		rvalid_d      = 1'b0;
		rthread_d     = '0;
		inq_d         = 1'b0;
		res_load      = 1'b0;
		q_cmd.op      = Q_NONE;
		q_cmd.tid     = tid_q;
		case (state_q)
			FSM_DECODE: begin
				res_load = !need_ring;
				case (req_q)
					REQ_WAIT: begin
						if (recursive_q && binary_q && owner_valid_q && (owner_q == tid_q)) begin
							status_d = ST_OK;
						end else if (count_q != '0) begin
							if (binary_q) begin
								owner_valid_d = 1'b1;
								owner_d       = tid_q;
							end
							count_d = count_q - cnt_t'(1);
						end else if (nowait_q) begin
							status_d = ST_WOULD_BLK;
						end else if (q_st.full) begin
							status_d = ST_Q_FULL;
						end else begin
							q_cmd.op = Q_PUSH;
							status_d = ST_QUEUED;
						end
					end
					REQ_POST: begin
						if (count_q >= COUNT_MAX) begin
							status_d = ST_OVERFLOW;
						end else if (q_st.empty) begin
							count_d = binary_q ? cnt_t'(1) : count_q + cnt_t'(1);
							if (binary_q) begin
								owner_valid_d = 1'b0;
								owner_d       = '0;
							end
						end else begin
							q_cmd.op = Q_POP;
						end
					end
					REQ_CANCEL: q_cmd.op = Q_CANCEL;
					REQ_PROBE:  q_cmd.op = Q_PROBE;
					REQ_SET: begin
						if (nc_q > COUNT_MAX) begin
							status_d = ST_BAD_VALUE;
						end else begin
							count_d = (binary_q && (nc_q != '0)) ? cnt_t'(1) : nc_q;
						end
					end
					default: status_d = ST_BAD_VALUE;
				endcase
			end
			FSM_QWAIT: begin
				res_load = q_st.done;
				case (req_q)
					REQ_POST: begin
						rvalid_d  = 1'b1;
						rthread_d = q_st.head_tid;
						if (binary_q && q_st.done) begin
							owner_valid_d = 1'b1;
							owner_d       = q_st.head_tid;
						end
					end
					REQ_CANCEL: status_d = q_st.hit ? ST_TIMED_OUT : ST_OK;
					REQ_PROBE:  inq_d = q_st.hit;
					default:    status_d = ST_OK;
				endcase
			end
			default: res_load = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			count_q       <= '0;
			owner_valid_q <= 1'b0;
			owner_q       <= '0;
			binary_q      <= 1'b0;
			recursive_q   <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			count_q       <= count_d;
			owner_valid_q <= owner_valid_d;
			owner_q       <= owner_d;
			done_q        <= res_load;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BINARY:    binary_q    <= cfg_data;
					CFG_RECURSIVE: recursive_q <= cfg_data;
					default:       binary_q    <= binary_q;
				endcase
			end
		end
	end

	// request capture and result registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q    <= req_t'(req_type);
			tid_q    <= thread_id[THREAD_BITS-1:0];
			nowait_q <= no_wait;
			nc_q     <= new_count[CNT_W-1:0];
		end
		if (res_load) begin
			status_q  <= status_d;
			rvalid_q  <= rvalid_d;
			rthread_q <= rthread_d;
			inq_q     <= inq_d;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign resume_valid  = rvalid_q;
	assign resume_thread = FIELD_W'(rthread_q);
	assign in_queue      = inq_q;
	assign count_value   = FIELD_W'(count_q);

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");
	a_qcmd_in_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cmd.op != Q_NONE) |-> (state_q == FSM_DECODE))
		else $error("ring command outside decode");
	a_qwait_has_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_DECODE) && need_ring |=> (state_q == FSM_QWAIT))
		else $error("ring request lost");
	a_resume_on_post: assert property (@(posedge clk) disable iff (!arst_n)
		done && resume_valid |-> (status == ST_OK))
		else $error("resume with a failing status");

endmodule
`default_nettype wire
